// ===== hdl/delayed_note_event_queue_top_macros.svh =====
// assertion macros shared by the queue top level
`ifndef DELAYED_NOTE_EVENT_QUEUE_TOP_MACROS_SVH
`define DELAYED_NOTE_EVENT_QUEUE_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define DNEQ_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dneq check failed");

// next-cycle implication, held off during reset
`define DNEQ_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dneq check failed");

`endif

// ===== hdl/dneq_pkg.sv =====
// types and constants for the delayed note event queue
`timescale 1ns / 1ps
package dneq_pkg;

  localparam int SLOTS_DEF   = 32;
  localparam int MAX_RESULTS = 32;
  localparam int NW          = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_SCHED  = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;

  localparam logic [1:0] ST_FREE      = 2'd0;
  localparam logic [1:0] ST_LIVE      = 2'd1;
  localparam logic [1:0] ST_CANCELLED = 2'd2;

  localparam logic [4:0] CNT_MAX = 5'd31;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [7:0] delay;
    logic [7:0] tag;
  } in_t;

  typedef struct packed {
    logic       event_valid;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
    logic [7:0] out_tag;
    logic       accepted;
    logic [4:0] cancel_count;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [6:0] note;
    logic [6:0] velocity;
    logic [7:0] delay;
    logic [7:0] tag;
  } rec_t;

  typedef struct packed {
    logic       busy;
    logic       full;
    logic       over;
  } eng_stat_t;

  typedef enum logic [3:0] {
    E_IDLE, E_T_CHK, E_T_HEAD, E_D_ISSUE, E_D_WB, E_T_FIN,
    E_S_FIND, E_S_INS, E_S_HCMP, E_S_NX, E_S_NCMP, E_S_SPL1, E_S_SPL2,
    E_C_ISSUE, E_C_CHK, E_EMIT
  } eng_state_t;

endpackage

// ===== hdl/delayed_note_event_queue_top.sv =====
// top level of the delayed note event queue
//
//  channel  signals                        beat contents
//  -------  -----------------------------  ------------------------------------
//  in       in_valid / in_ready / in_data  mode, note, velocity, delay, tag
//  out      out_valid / out_ready / out_data  expired event or op status, last
//
//  one item at a time; in_ready is high only while the sequencer is idle
//  schedule: free-slot scan upward from slot 1, then a walk of the list to the insert point
//  tick: pops zero-delay entries at the head, then ages each remaining entry
//  cancel: reads every list entry in turn; the single memory read port sets pace
//  rst is synchronous: slot status all free, list empty, no beat pending
//  a stalled out channel holds the sequencer in place; nothing is dropped
`timescale 1ns / 1ps
`include "delayed_note_event_queue_top_macros.svh"
module delayed_note_event_queue_top #(
  parameter int SLOTS = dneq_pkg::SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dneq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dneq_pkg::out_t out_data
);

  // beat from the sequencer into the output register
  logic                emit_valid;
  logic                emit_ready;
  dneq_pkg::out_t      emit_data;
  dneq_pkg::eng_stat_t eng_stat;

  // list walker with slot pool
  dneq_engine #(
    .SLOTS(SLOTS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .emit_valid(emit_valid),
    .emit_data (emit_data),
    .emit_ready(emit_ready),
    .status    (eng_stat)
  );

  // output register decouples the sequencer from the consumer
  dneq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push_valid(emit_valid),
    .push_data (emit_data),
    .push_ready(emit_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // an accepted item always keeps the sequencer busy the next cycle
  `DNEQ_AST_NXT(a_busy_after_accept, in_valid && in_ready, eng_stat.busy && !in_ready)
  // the sequencer never offers a beat while taking input
  `DNEQ_AST_NOW(a_no_emit_idle, in_ready, !emit_valid)
  // pool never holds more than the slots beside the sentinel
  `DNEQ_AST_NOW(a_occ_bound, 1'b1, !eng_stat.over)

endmodule

// ===== hdl/dneq_out_buf.sv =====
// single-entry output register for result beats
`timescale 1ns / 1ps
module dneq_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  dneq_pkg::out_t push_data,
  output logic          push_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output dneq_pkg::out_t out_data
);

  logic full;
  dneq_pkg::out_t data;

  assign push_ready = !full || out_ready;
  assign out_valid  = full;
  assign out_data   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push_valid && push_ready) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      data <= push_data;
    end
  end

endmodule

// ===== hdl/dneq_engine.sv =====
// slot pool, list walker and sequencer for the event queue
`timescale 1ns / 1ps
module dneq_engine #(
  parameter int SLOTS = dneq_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  dneq_pkg::in_t      in_data,
  output logic               in_ready,
  output logic               emit_valid,
  output dneq_pkg::out_t     emit_data,
  input  logic               emit_ready,
  output dneq_pkg::eng_stat_t status
);

  localparam int IW = $clog2(SLOTS);
  localparam int OW = $clog2(SLOTS + 1);
  localparam logic [OW-1:0] OCC_MAX = OW'(SLOTS - 1);
  localparam logic [dneq_pkg::NW-1:0] N_MAX = dneq_pkg::NW'(dneq_pkg::MAX_RESULTS);

  // slot storage
  dneq_pkg::rec_t rec_mem [SLOTS];
  logic [IW-1:0]  link_mem [SLOTS];
  logic [1:0]     stat [SLOTS];

  dneq_pkg::rec_t rd_rec;
  logic [IW-1:0]  rd_link;
  logic [IW-1:0]  rd_addr;

  logic           rec_we;
  logic [IW-1:0]  rec_waddr;
  dneq_pkg::rec_t rec_wdata;
  logic           link_we;
  logic [IW-1:0]  link_waddr;
  logic [IW-1:0]  link_wdata;
  logic           st_we;
  logic [IW-1:0]  sidx;
  logic [1:0]     st_wdata;
  logic [1:0]     st_rd;

  dneq_pkg::eng_state_t state, state_next;
  dneq_pkg::in_t  item, item_next;
  logic [IW-1:0]  head, head_next;
  logic [OW-1:0]  occ, occ_next;
  logic [IW-1:0]  cur, cur_next;
  logic [IW-1:0]  nx, nx_next;
  logic [IW-1:0]  pos, pos_next;
  logic [IW-1:0]  fs, fs_next;
  logic [dneq_pkg::NW-1:0] n, n_next;
  dneq_pkg::out_t pend, pend_next;
  logic           pend_valid, pend_valid_next;
  logic [4:0]     cnt, cnt_next;
  dneq_pkg::out_t res, res_next;

  dneq_pkg::out_t empty_res;
  dneq_pkg::out_t acc_res;
  dneq_pkg::rec_t dec_rec;

  assign st_rd = stat[sidx];

  always_comb begin
    empty_res      = '0;
    empty_res.last = 1'b1;
    acc_res          = empty_res;
    acc_res.accepted = 1'b1;
    dec_rec = rd_rec;
    if (rd_rec.delay != 8'd0) begin
      dec_rec.delay = rd_rec.delay - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    rd_rec  <= rec_mem[rd_addr];
    rd_link <= link_mem[rd_addr];
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        stat[i] <= dneq_pkg::ST_FREE;
      end
    end else if (st_we) begin
      stat[sidx] <= st_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dneq_pkg::E_IDLE;
      head       <= '0;
      occ        <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      occ        <= occ_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    cur  <= cur_next;
    nx   <= nx_next;
    pos  <= pos_next;
    fs   <= fs_next;
    n    <= n_next;
    pend <= pend_next;
    cnt  <= cnt_next;
    res  <= res_next;
  end

  always_comb begin
    state_next      = state;
    item_next       = item;
    head_next       = head;
    occ_next        = occ;
    cur_next        = cur;
    nx_next         = nx;
    pos_next        = pos;
    fs_next         = fs;
    n_next          = n;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    cnt_next        = cnt;
    res_next        = res;
    in_ready        = 1'b0;
    emit_valid      = 1'b0;
    emit_data       = pend;
    rd_addr         = head;
    rec_we          = 1'b0;
    rec_waddr       = cur;
    rec_wdata       = dec_rec;
    link_we         = 1'b0;
    link_waddr      = fs;
    link_wdata      = nx;
    st_we           = 1'b0;
    sidx            = cur;
    st_wdata        = dneq_pkg::ST_FREE;

    unique case (state)
      dneq_pkg::E_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_next = in_data;
          unique case (in_data.mode)
            dneq_pkg::MODE_TICK: begin
              n_next          = '0;
              pend_valid_next = 1'b0;
              state_next      = dneq_pkg::E_T_CHK;
            end
            dneq_pkg::MODE_SCHED: begin
              if (occ == OCC_MAX) begin
                res_next   = empty_res;
                state_next = dneq_pkg::E_EMIT;
              end else begin
                cur_next   = IW'(1);
                state_next = dneq_pkg::E_S_FIND;
              end
            end
            dneq_pkg::MODE_CANCEL: begin
              cur_next   = head;
              cnt_next   = '0;
              state_next = dneq_pkg::E_C_ISSUE;
            end
            default: begin
              res_next   = empty_res;
              state_next = dneq_pkg::E_EMIT;
            end
          endcase
        end
      end

      // pop zero-delay entries at the head
      dneq_pkg::E_T_CHK: begin
        rd_addr = head;
        if (head == '0) begin
          cur_next   = '0;
          state_next = dneq_pkg::E_D_ISSUE;
        end else begin
          state_next = dneq_pkg::E_T_HEAD;
        end
      end

      dneq_pkg::E_T_HEAD: begin
        rd_addr = head;
        sidx    = head;
        if (rd_rec.delay != 8'd0) begin
          cur_next   = head;
          state_next = dneq_pkg::E_D_ISSUE;
        end else if (st_rd == dneq_pkg::ST_LIVE) begin
          if (n == N_MAX) begin
            cur_next   = head;
            state_next = dneq_pkg::E_D_ISSUE;
          end else begin
            emit_valid = pend_valid;
            if (!pend_valid || emit_ready) begin
              pend_next              = '0;
              pend_next.event_valid  = 1'b1;
              pend_next.out_note     = rd_rec.note;
              pend_next.out_velocity = rd_rec.velocity;
              pend_next.out_tag      = rd_rec.tag;
              pend_valid_next        = 1'b1;
              n_next                 = n + 1'b1;
              st_we                  = 1'b1;
              head_next              = rd_link;
              occ_next               = occ - 1'b1;
              state_next             = dneq_pkg::E_T_CHK;
            end
          end
        end else begin
          st_we      = 1'b1;
          head_next  = rd_link;
          occ_next   = occ - 1'b1;
          state_next = dneq_pkg::E_T_CHK;
        end
      end

      // age every remaining entry
      dneq_pkg::E_D_ISSUE: begin
        rd_addr = cur;
        if (cur == '0) begin
          state_next = dneq_pkg::E_T_FIN;
        end else begin
          state_next = dneq_pkg::E_D_WB;
        end
      end

      dneq_pkg::E_D_WB: begin
        rec_we     = 1'b1;
        rec_waddr  = cur;
        cur_next   = rd_link;
        state_next = dneq_pkg::E_D_ISSUE;
      end

      dneq_pkg::E_T_FIN: begin
        emit_valid = 1'b1;
        if (pend_valid) begin
          emit_data      = pend;
          emit_data.last = 1'b1;
        end else begin
          emit_data = empty_res;
        end
        if (emit_ready) begin
          pend_valid_next = 1'b0;
          state_next      = dneq_pkg::E_IDLE;
        end
      end

      // lowest free slot above the sentinel, one per cycle
      dneq_pkg::E_S_FIND: begin
        sidx = cur;
        if (st_rd == dneq_pkg::ST_FREE) begin
          fs_next    = cur;
          state_next = dneq_pkg::E_S_INS;
        end else begin
          cur_next = cur + 1'b1;
        end
      end

      dneq_pkg::E_S_INS: begin
        rec_we             = 1'b1;
        rec_waddr          = fs;
        rec_wdata.note     = item.note;
        rec_wdata.velocity = item.velocity;
        rec_wdata.delay    = item.delay;
        rec_wdata.tag      = item.tag;
        st_we              = 1'b1;
        sidx               = fs;
        st_wdata           = dneq_pkg::ST_LIVE;
        occ_next           = occ + 1'b1;
        rd_addr            = head;
        if (head == '0) begin
          link_we    = 1'b1;
          link_wdata = '0;
          head_next  = fs;
          res_next   = acc_res;
          state_next = dneq_pkg::E_EMIT;
        end else begin
          state_next = dneq_pkg::E_S_HCMP;
        end
      end

      dneq_pkg::E_S_HCMP: begin
        if (item.delay < rd_rec.delay) begin
          link_we    = 1'b1;
          link_wdata = head;
          head_next  = fs;
          res_next   = acc_res;
          state_next = dneq_pkg::E_EMIT;
        end else begin
          pos_next   = head;
          nx_next    = rd_link;
          state_next = dneq_pkg::E_S_NX;
        end
      end

      dneq_pkg::E_S_NX: begin
        rd_addr = nx;
        if (nx == '0) begin
          state_next = dneq_pkg::E_S_SPL1;
        end else begin
          state_next = dneq_pkg::E_S_NCMP;
        end
      end

      dneq_pkg::E_S_NCMP: begin
        if (item.delay < rd_rec.delay) begin
          state_next = dneq_pkg::E_S_SPL1;
        end else begin
          pos_next   = nx;
          nx_next    = rd_link;
          state_next = dneq_pkg::E_S_NX;
        end
      end

      dneq_pkg::E_S_SPL1: begin
        link_we    = 1'b1;
        link_waddr = fs;
        link_wdata = nx;
        state_next = dneq_pkg::E_S_SPL2;
      end

      dneq_pkg::E_S_SPL2: begin
        link_we    = 1'b1;
        link_waddr = pos;
        link_wdata = fs;
        res_next   = acc_res;
        state_next = dneq_pkg::E_EMIT;
      end

      // cancel walk
      dneq_pkg::E_C_ISSUE: begin
        rd_addr = cur;
        if (cur == '0) begin
          res_next              = empty_res;
          res_next.cancel_count = cnt;
          state_next            = dneq_pkg::E_EMIT;
        end else begin
          state_next = dneq_pkg::E_C_CHK;
        end
      end

      dneq_pkg::E_C_CHK: begin
        sidx = cur;
        if (st_rd == dneq_pkg::ST_LIVE && rd_rec.note == item.note &&
            rd_rec.velocity == item.velocity) begin
          st_we    = 1'b1;
          st_wdata = dneq_pkg::ST_CANCELLED;
          if (cnt != dneq_pkg::CNT_MAX) begin
            cnt_next = cnt + 1'b1;
          end
        end
        cur_next   = rd_link;
        state_next = dneq_pkg::E_C_ISSUE;
      end

      dneq_pkg::E_EMIT: begin
        emit_valid = 1'b1;
        emit_data  = res;
        if (emit_ready) begin
          state_next = dneq_pkg::E_IDLE;
        end
      end

      default: begin
        state_next = dneq_pkg::E_IDLE;
      end
    endcase
  end

  always_comb begin
    status.busy = (state != dneq_pkg::E_IDLE);
    status.full = (occ == OCC_MAX);
    status.over = (occ > OCC_MAX);
  end

endmodule
